/* rtl/core/cagc_pkg.sv */
// Shared types, constants and a helper function for the cell age gradient colorizer.
// Has no dependencies. Every other file in rtl/core uses it by scoped names.
`default_nettype none

package cagc_pkg;

  localparam int PALETTE_POINTS = 4;
  localparam int CNT_W = 3;
  localparam int IDX_W = $clog2(PALETTE_POINTS);
  localparam int PAL_W = 32 * PALETTE_POINTS;
  localparam int DIV_STAGES = 4;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_FILL       = 3'd1;
  localparam logic [2:0] REG_LIVE_COUNT = 3'd2;
  localparam logic [2:0] REG_DEAD_COUNT = 3'd3;
  localparam logic [2:0] REG_LIVE_LOW   = 3'd4;
  localparam logic [2:0] REG_LIVE_HIGH  = 3'd5;
  localparam logic [2:0] REG_DEAD_LOW   = 3'd6;
  localparam logic [2:0] REG_DEAD_HIGH  = 3'd7;

  localparam logic [1:0] MODE_INVERTED = 2'd1;
  localparam logic [7:0] FILL_CELL = 8'd127;
  localparam logic [7:0] FULL_ON = 8'd255;

  typedef struct packed {
    logic [1:0]       mode;
    logic [23:0]      fill;
    logic [CNT_W-1:0] live_count;
    logic [CNT_W-1:0] dead_count;
    logic [PAL_W-1:0] live_pts;
    logic [PAL_W-1:0] dead_pts;
  } cfg_t;

  typedef struct packed {
    logic        direct;
    logic [23:0] color;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [6:0]  age;
  } sel_t;

  typedef struct packed {
    logic            direct;
    logic [23:0]     color;
    logic [8:0]      dvs;
    logic [2:0][8:0] rem;
    logic [2:0][7:0] nlow;
    logic [2:0][7:0] quo;
  } div_t;

  // One restoring division step: returns the quotient bit over the new remainder.
  function automatic logic [9:0] div_step(input logic [8:0] rem, input logic nbit,
                                          input logic [8:0] dvs);
    logic [9:0] t;
    t = {rem, nbit};
    if (t >= {1'b0, dvs}) begin
      div_step = {1'b1, 9'(t - {1'b0, dvs})};
    end else begin
      div_step = {1'b0, t[8:0]};
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cell_age_gradient_colorizer.sv */
// Top level of the cell age gradient colorizer: configuration registers, pipeline, output.
// Depends on cagc_pkg, cagc_select, cagc_mul and cagc_div.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata[7:0] cell_byte
//   m_axis    out        tdata[7:0] red, [15:8] green, [23:16] blue
//   cfg       in         cfg_we, cfg_addr register index, cfg_data value
//
// One cell is taken every cycle while m_axis is not stalled; there are seven register
// stages (select, multiply, four divider stages and the output register), and each
// request passes through them in that order on its way to m_axis.
// Reset restores the register defaults and empties the pipeline.
// A stall on m_axis holds every stage at once, and s_axis_tready drops with it.
`default_nettype none

module cell_age_gradient_colorizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] cell_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [63:0] cfg_data
);

  cagc_pkg::cfg_t cfg;
  logic adv;
  logic sel_valid;
  cagc_pkg::sel_t sel;
  logic mul_valid;
  cagc_pkg::div_t mul_div;
  logic div_valid;
  cagc_pkg::div_t div_out;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= 2'd0;
      cfg.fill <= 24'd0;
      cfg.live_count <= cagc_pkg::CNT_W'(1);
      cfg.dead_count <= cagc_pkg::CNT_W'(1);
      cfg.live_pts <= '0;
      cfg.dead_pts <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        cagc_pkg::REG_MODE:       cfg.mode <= cfg_data[1:0];
        cagc_pkg::REG_FILL:       cfg.fill <= cfg_data[23:0];
        cagc_pkg::REG_LIVE_COUNT: cfg.live_count <= cfg_data[cagc_pkg::CNT_W-1:0];
        cagc_pkg::REG_DEAD_COUNT: cfg.dead_count <= cfg_data[cagc_pkg::CNT_W-1:0];
        cagc_pkg::REG_LIVE_LOW:   cfg.live_pts[63:0] <= cfg_data;
        cagc_pkg::REG_LIVE_HIGH:  cfg.live_pts[127:64] <= cfg_data;
        cagc_pkg::REG_DEAD_LOW:   cfg.dead_pts[63:0] <= cfg_data;
        cagc_pkg::REG_DEAD_HIGH:  cfg.dead_pts[127:64] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cagc_select u_select (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_axis_tvalid),
    .cell_byte (s_axis_tdata),
    .cfg       (cfg),
    .out_valid (sel_valid),
    .out_sel   (sel)
  );

  cagc_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sel_valid),
    .in_sel    (sel),
    .out_valid (mul_valid),
    .out_div   (mul_div)
  );

  cagc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (mul_valid),
    .in_div    (mul_div),
    .out_valid (div_valid),
    .out_div   (div_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= div_valid;
    end
    if (adv) begin
      if (div_out.direct) begin
        m_axis_tdata <= {div_out.color[7:0], div_out.color[15:8], div_out.color[23:16]};
      end else begin
        m_axis_tdata <= {div_out.quo[0], div_out.quo[1], div_out.quo[2]};
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cagc_select.sv */
// First pipeline stage: decodes the mode and finds the palette segment for one cell.
// Depends on cagc_pkg.
`default_nettype none

module cagc_select (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire logic [7:0]    cell_byte,
  input  cagc_pkg::cfg_t     cfg,
  output logic               out_valid,
  output cagc_pkg::sel_t     out_sel
);

  logic [31:0] word [cagc_pkg::PALETTE_POINTS];
  logic [cagc_pkg::PAL_W-1:0] pal;
  logic [cagc_pkg::CNT_W-1:0] cnt;
  logic [cagc_pkg::CNT_W-1:0] n;
  logic [31:0] last;
  logic [6:0] age;
  logic alive;
  logic found;
  logic [7:0] on;
  logic [7:0] v;
  cagc_pkg::sel_t sel_next;

  always_comb begin
    alive = cell_byte[7];
    age = cell_byte[6:0];
    pal = alive ? cfg.live_pts : cfg.dead_pts;
    cnt = alive ? cfg.live_count : cfg.dead_count;
    for (int i = 0; i < cagc_pkg::PALETTE_POINTS; i++) begin
      word[i] = pal[32*i +: 32];
    end
    n = cnt;
    if (cnt == '0) begin
      n = cagc_pkg::CNT_W'(1);
    end else if (cnt > cagc_pkg::CNT_W'(cagc_pkg::PALETTE_POINTS)) begin
      n = cagc_pkg::CNT_W'(cagc_pkg::PALETTE_POINTS);
    end
    last = word[cagc_pkg::IDX_W'(n - cagc_pkg::CNT_W'(1))];
    on = (cfg.mode == cagc_pkg::MODE_INVERTED) ? 8'd0 : cagc_pkg::FULL_ON;
    v = alive ? on : ~on;

    sel_next.age = age;
    sel_next.lo = last;
    sel_next.hi = last;
    sel_next.direct = 1'b1;
    sel_next.color = last[23:0];
    found = 1'b0;
    for (int c = 1; c < cagc_pkg::PALETTE_POINTS; c++) begin
      if (!found && (cagc_pkg::CNT_W'(c) < n) && (word[c][31:24] > {1'b0, age})) begin
        found = 1'b1;
        sel_next.lo = word[c-1];
        sel_next.hi = word[c];
      end
    end

    if (!cfg.mode[1]) begin
      sel_next.color = {v, v, v};
    end else if (cell_byte == cagc_pkg::FILL_CELL) begin
      sel_next.color = cfg.fill;
    end else if (word[0][31:24] >= {1'b0, age}) begin
      sel_next.color = word[0][23:0];
    end else if (last[31:24] <= {1'b0, age}) begin
      sel_next.color = last[23:0];
    end else if (found) begin
      sel_next.direct = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_sel <= sel_next;
    end
  end

  a_segment_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_sel.direct) |->
      (out_sel.lo[31:24] <= {1'b0, out_sel.age}) && (out_sel.hi[31:24] > {1'b0, out_sel.age}))
    else $error("interpolation segment does not bracket the age");

endmodule

`default_nettype wire

/* rtl/core/cagc_mul.sv */
// Second pipeline stage: forms the interpolation numerator per channel and the shared divisor.
// Depends on cagc_pkg.
`default_nettype none

module cagc_mul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  cagc_pkg::sel_t     in_sel,
  output logic               out_valid,
  output cagc_pkg::div_t     out_div
);

  logic [7:0] d;
  logic [7:0] off;
  logic [7:0] lv [3];
  logic [7:0] hv [3];
  logic [15:0] base [3];
  logic signed [8:0] diff [3];
  logic signed [17:0] prod [3];
  logic signed [18:0] num [3];
  logic [15:0] nn [3];
  logic [16:0] dividend [3];
  cagc_pkg::div_t div_next;

  always_comb begin
    d = in_sel.hi[31:24] - in_sel.lo[31:24];
    if (d == 8'd0) begin
      d = 8'd1;
    end
    off = {1'b0, in_sel.age} - in_sel.lo[31:24];
    div_next.direct = in_sel.direct;
    div_next.color = in_sel.color;
    div_next.dvs = {d, 1'b0};
    for (int j = 0; j < 3; j++) begin
      lv[j] = in_sel.lo[8*j +: 8];
      hv[j] = in_sel.hi[8*j +: 8];
      base[j] = 16'(lv[j]) * 16'(d);
      diff[j] = $signed({1'b0, hv[j]}) - $signed({1'b0, lv[j]});
      prod[j] = 18'($signed({1'b0, off})) * 18'(diff[j]);
      num[j] = $signed({3'b000, base[j]}) + $signed({prod[j][17], prod[j]});
      nn[j] = num[j][18] ? 16'd0 : num[j][15:0];
      dividend[j] = {nn[j], 1'b0} + {9'd0, d};
      div_next.rem[j] = dividend[j][16:8];
      div_next.nlow[j] = dividend[j][7:0];
      div_next.quo[j] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_div <= div_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cagc_div.sv */
// Pipelined restoring divider, two quotient bits per stage, three channels side by side.
// Depends on cagc_pkg.
`default_nettype none

module cagc_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  cagc_pkg::div_t     in_div,
  output logic               out_valid,
  output cagc_pkg::div_t     out_div
);

  cagc_pkg::div_t st [cagc_pkg::DIV_STAGES];
  cagc_pkg::div_t nxt [cagc_pkg::DIV_STAGES];
  logic vld [cagc_pkg::DIV_STAGES];
  logic [9:0] r;

  always_comb begin
    r = '0;
    nxt[0] = in_div;
    for (int k = 1; k < cagc_pkg::DIV_STAGES; k++) begin
      nxt[k] = st[k-1];
    end
    for (int k = 0; k < cagc_pkg::DIV_STAGES; k++) begin
      for (int s = 0; s < 2; s++) begin
        for (int j = 0; j < 3; j++) begin
          r = cagc_pkg::div_step(nxt[k].rem[j], nxt[k].nlow[j][7], nxt[k].dvs);
          nxt[k].rem[j] = r[8:0];
          nxt[k].quo[j] = {nxt[k].quo[j][6:0], r[9]};
          nxt[k].nlow[j] = {nxt[k].nlow[j][6:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
    for (int k = 1; k < cagc_pkg::DIV_STAGES; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= vld[k-1];
      end
    end
    for (int k = 0; k < cagc_pkg::DIV_STAGES; k++) begin
      if (adv) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign out_valid = vld[cagc_pkg::DIV_STAGES-1];
  assign out_div = st[cagc_pkg::DIV_STAGES-1];

  a_rem_first: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && !st[0].direct) |->
      (st[0].rem[0] < st[0].dvs) && (st[0].rem[1] < st[0].dvs) && (st[0].rem[2] < st[0].dvs))
    else $error("divider remainder out of range after first stage");

  a_rem_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_div.direct) |->
      (out_div.rem[0] < out_div.dvs) && (out_div.rem[1] < out_div.dvs)
      && (out_div.rem[2] < out_div.dvs))
    else $error("divider remainder out of range at the last stage");

  a_divisor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_div.direct) |-> (out_div.dvs != 9'd0) && !out_div.dvs[0])
    else $error("divisor is not twice a nonzero key distance");

endmodule

`default_nettype wire
